[hw/rtl/dbpe_pkg.sv]
// shared types and constants for the dot-bracket pair extractor
package dbpe_pkg;

    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_POS_WIDTH   = 16;
    localparam int NUM_KINDS       = 4;
    localparam int SYM_WIDTH       = 4;
    localparam int KIND_WIDTH      = 2;

    localparam logic [SYM_WIDTH-1:0] SYM_UNPAIRED      = 4'd0;
    localparam logic [SYM_WIDTH-1:0] SYM_ROUND_OPEN    = 4'd1;
    localparam logic [SYM_WIDTH-1:0] SYM_ROUND_CLOSE   = 4'd2;
    localparam logic [SYM_WIDTH-1:0] SYM_SQUARE_OPEN   = 4'd3;
    localparam logic [SYM_WIDTH-1:0] SYM_SQUARE_CLOSE  = 4'd4;
    localparam logic [SYM_WIDTH-1:0] SYM_CURLY_OPEN    = 4'd5;
    localparam logic [SYM_WIDTH-1:0] SYM_CURLY_CLOSE   = 4'd6;
    localparam logic [SYM_WIDTH-1:0] SYM_CHEVRON_OPEN  = 4'd7;
    localparam logic [SYM_WIDTH-1:0] SYM_CHEVRON_CLOSE = 4'd8;
    localparam logic [SYM_WIDTH-1:0] SYM_SEPARATOR     = 4'd9;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_ROUND   = 2'd0,
        KIND_SQUARE  = 2'd1,
        KIND_CURLY   = 2'd2,
        KIND_CHEVRON = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stk_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } stk_stat_t;

endpackage

[hw/rtl/dbpe_stack_cell.sv]
// one entry of the shift-register stack
module dbpe_stack_cell
    import dbpe_pkg::*;
#(
    parameter int POS_WIDTH = DEF_POS_WIDTH
) (
    input  logic                 aclk,
    input  logic                 push,
    input  logic                 pop,
    input  logic [POS_WIDTH-1:0] above_val,
    input  logic [POS_WIDTH-1:0] below_val,
    output logic [POS_WIDTH-1:0] val
);

    logic [POS_WIDTH-1:0] val_reg;
    logic [POS_WIDTH-1:0] val_next;

    always_comb begin
        priority if (push) begin
            val_next = above_val;
        end else if (pop) begin
            val_next = below_val;
        end else begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

[hw/rtl/dbpe_stack.sv]
// bracket stack built as a row of shifting cells plus a fill level
module dbpe_stack
    import dbpe_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int POS_WIDTH   = DEF_POS_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  stk_ctrl_t            ctrl,
    input  logic [POS_WIDTH-1:0] push_data,
    output logic [POS_WIDTH-1:0] top,
    output stk_stat_t            stat
);

    localparam int LW = $clog2(STACK_DEPTH + 1);

    logic [LW-1:0]        level_reg;
    logic [LW-1:0]        level_next;
    logic [POS_WIDTH-1:0] cell_val [STACK_DEPTH];

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
            logic [POS_WIDTH-1:0] above;
            logic [POS_WIDTH-1:0] below;
            if (i == 0) begin : g_first
                assign above = push_data;
            end else begin : g_mid_above
                assign above = cell_val[i-1];
            end
            if (i == STACK_DEPTH - 1) begin : g_last
                assign below = cell_val[i];
            end else begin : g_mid_below
                assign below = cell_val[i+1];
            end
            dbpe_stack_cell #(
                .POS_WIDTH (POS_WIDTH)
            ) u_cell (
                .aclk      (aclk),
                .push      (ctrl.push),
                .pop       (ctrl.pop),
                .above_val (above),
                .below_val (below),
                .val       (cell_val[i])
            );
        end
    endgenerate

    always_comb begin
        priority if (ctrl.clear) begin
            level_next = ctrl.push ? LW'(1) : '0;
        end else if (ctrl.push) begin
            level_next = level_reg + LW'(1);
        end else if (ctrl.pop) begin
            level_next = level_reg - LW'(1);
        end else begin
            level_next = level_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else begin
            level_reg <= level_next;
        end
    end

    assign top        = cell_val[0];
    assign stat.empty = (level_reg == '0);
    assign stat.full  = (level_reg == LW'(STACK_DEPTH));

    a_push_pop_excl : assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.push && ctrl.pop))
        else $error("push and pop together");

    a_level_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_push_top : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |=> top == $past(push_data))
        else $error("pushed value not on top");

    a_pop_level : assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.pop && !ctrl.clear) |=> level_reg == $past(level_reg) - LW'(1))
        else $error("pop did not lower level");

endmodule

[hw/rtl/dot_bracket_pair_extractor.sv]
// a result is registered and shown in the cycle after its request is accepted
// throughput: one symbol per cycle while the result side takes results; each stack is a row
// of cells shifting once per push or pop, and the position update is one add per symbol
// a waiting result holds off new requests until it is taken; both move in the same cycle
// reset (aresetn low, synchronous): position, stack levels and output valid clear;
// stack cells are not reset and need no clearing pass
module dot_bracket_pair_extractor
    import dbpe_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int POS_WIDTH   = DEF_POS_WIDTH,
    localparam int DATA_BITS  = SYM_WIDTH + 2 * POS_WIDTH,
    localparam int DW         = ((DATA_BITS + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // symbol, comp_start, prev_comp_end
    input  logic [DW-1:0] s_tdata,
    // first_of_motif
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // open_pos, close_pos, bracket_kind, status
    output logic [DW-1:0] m_tdata,
    // pair_valid
    output logic          m_tuser
);

    localparam int PAD = DW - DATA_BITS;

    logic [SYM_WIDTH-1:0] sym;
    logic [POS_WIDTH-1:0] comp_start;
    logic [POS_WIDTH-1:0] prev_end;
    logic                 first;
    logic                 accept;

    logic [POS_WIDTH-1:0] pos_reg;
    logic [POS_WIDTH-1:0] pos_next;
    logic [POS_WIDTH-1:0] cur_pos;

    logic [SYM_WIDTH-1:0] sym_m1;
    logic                 is_bracket;
    logic                 is_open;
    kind_t                kind;
    logic                 empty_eff;
    logic                 full_eff;

    stk_ctrl_t            ctrl [NUM_KINDS];
    stk_stat_t            stat [NUM_KINDS];
    logic [POS_WIDTH-1:0] top  [NUM_KINDS];

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 pair_reg;
    logic                 pair_next;
    logic [POS_WIDTH-1:0] open_reg;
    logic [POS_WIDTH-1:0] open_next;
    logic [POS_WIDTH-1:0] close_reg;
    logic [POS_WIDTH-1:0] close_next;
    kind_t                kind_reg;
    kind_t                kind_next;
    status_t              status_reg;
    status_t              status_next;

    assign sym        = s_tdata[SYM_WIDTH-1:0];
    assign comp_start = s_tdata[SYM_WIDTH +: POS_WIDTH];
    assign prev_end   = s_tdata[SYM_WIDTH + POS_WIDTH +: POS_WIDTH];
    assign first      = s_tuser;

    assign s_tready = aresetn && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // bracket decode
    assign sym_m1     = sym - SYM_ROUND_OPEN;
    assign is_bracket = (sym >= SYM_ROUND_OPEN) && (sym <= SYM_CHEVRON_CLOSE);
    assign is_open    = sym[0];
    assign kind       = is_bracket ? kind_t'(sym_m1[2:1]) : KIND_ROUND;
    assign empty_eff  = first || stat[kind].empty;
    assign full_eff   = !first && stat[kind].full;

    // position of this symbol
    assign cur_pos = first ? comp_start : pos_reg;

    always_comb begin
        unique case (sym)
            SYM_SEPARATOR: begin
                pos_next = first ? comp_start
                                 : pos_reg + comp_start - prev_end - POS_WIDTH'(1);
            end
            default: begin
                pos_next = cur_pos + POS_WIDTH'(1);
            end
        endcase
    end

    genvar k;
    generate
        for (k = 0; k < NUM_KINDS; k++) begin : g_stack
            assign ctrl[k].clear = accept && first;
            assign ctrl[k].push  = accept && is_bracket && is_open && (kind == kind_t'(k))
                                   && !full_eff;
            assign ctrl[k].pop   = accept && is_bracket && !is_open && (kind == kind_t'(k))
                                   && !empty_eff;
            dbpe_stack #(
                .STACK_DEPTH (STACK_DEPTH),
                .POS_WIDTH   (POS_WIDTH)
            ) u_stack (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl[k]),
                .push_data (cur_pos),
                .top       (top[k]),
                .stat      (stat[k])
            );
        end
    endgenerate

    // result of this symbol
    always_comb begin
        pair_next   = 1'b0;
        open_next   = '0;
        close_next  = '0;
        kind_next   = kind;
        status_next = STATUS_OK;
        if (is_bracket) begin
            if (is_open) begin
                if (full_eff) begin
                    status_next = STATUS_FULL;
                end
            end else begin
                if (empty_eff) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    pair_next  = 1'b1;
                    open_next  = top[kind];
                    close_next = cur_pos;
                end
            end
        end
    end

    always_comb begin
        priority if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pair_reg   <= pair_next;
            open_reg   <= open_next;
            close_reg  <= close_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = pair_reg;
    assign m_tdata  = {{PAD{1'b0}}, status_reg, kind_reg, close_reg, open_reg};

endmodule

[sim/dot_bracket_pair_extractor_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the dot-bracket pair extractor stream block
module dot_bracket_pair_extractor_tb;
    import dbpe_pkg::*;

    localparam int STACK_DEPTH = DEF_STACK_DEPTH;
    localparam int POS_W       = DEF_POS_WIDTH;
    localparam int DW          = ((SYM_WIDTH + 2 * POS_W + 7) / 8) * 8;
    localparam int ITEM_TARGET = 1720;
    localparam int IDLE_LIMIT  = 2000;

    typedef struct packed {
        logic [SYM_WIDTH-1:0] symbol;
        logic                 first;
        logic [POS_W-1:0]     comp_start;
        logic [POS_W-1:0]     prev_end;
    } request_t;

    typedef struct packed {
        logic             pair_valid;
        logic [POS_W-1:0] open_pos;
        logic [POS_W-1:0] close_pos;
        kind_t            kind;
        status_t          status;
    } pair_result_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    // symbol, comp_start, prev_comp_end
    logic [DW-1:0] s_tdata  = '0;
    // first_of_motif
    logic          s_tuser  = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    // open_pos, close_pos, bracket_kind, status
    logic [DW-1:0] m_tdata;
    // pair_valid
    logic          m_tuser;

    request_t     requests[$];
    pair_result_t expected_pairs[$];
    int           queued = 0;
    int           errors = 0;
    int           send_gap = 0;
    int           send_quiet = 0;
    int           stall_left = 0;
    int           stall_quiet = 0;
    int           idle_cycles = 0;

    logic [POS_W-1:0] pos_stacks [NUM_KINDS][STACK_DEPTH];
    int               stack_fill [NUM_KINDS];
    logic [POS_W-1:0] next_pos;

    dot_bracket_pair_extractor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    task automatic add_request(input logic [SYM_WIDTH-1:0] sym, input logic first,
                               input logic [POS_W-1:0] cs, input logic [POS_W-1:0] pe);
        request_t rq;
        rq.symbol     = sym;
        rq.first      = first;
        rq.comp_start = cs;
        rq.prev_end   = pe;
        requests.insert(requests.size(), rq);
        queued++;
    endtask

    // mostly short gaps, some long ones, and quiet stretches with none
    function automatic int next_gap(inout int quiet);
        int r;
        if (quiet != 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pair_result_t track_symbol(request_t rq);
        pair_result_t res;
        kind_t        k;
        res.pair_valid = 1'b0;
        res.open_pos   = '0;
        res.close_pos  = '0;
        res.kind       = KIND_ROUND;
        res.status     = STATUS_OK;
        if (rq.first) begin
            for (int i = 0; i < NUM_KINDS; i++) stack_fill[i] = 0;
            next_pos = rq.comp_start;
        end
        if (rq.symbol == SYM_SEPARATOR) begin
            if (!rq.first) next_pos = next_pos + rq.comp_start - rq.prev_end - 1'b1;
        end else begin
            if (rq.symbol >= SYM_ROUND_OPEN && rq.symbol <= SYM_CHEVRON_CLOSE) begin
                k = kind_t'(2'((rq.symbol - SYM_ROUND_OPEN) >> 1));
                res.kind = k;
                if (rq.symbol[0]) begin
                    if (stack_fill[k] >= STACK_DEPTH) begin
                        res.status = STATUS_FULL;
                    end else begin
                        pos_stacks[k][stack_fill[k]] = next_pos;
                        stack_fill[k]++;
                    end
                end else if (stack_fill[k] == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    stack_fill[k]--;
                    res.pair_valid = 1'b1;
                    res.open_pos   = pos_stacks[k][stack_fill[k]];
                    res.close_pos  = next_pos;
                end
            end
            next_pos = next_pos + 1'b1;
        end
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (s_tvalid && !s_tready) begin
        end else if (send_gap != 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (requests.size() != 0) begin
            request_t rq;
            rq = requests.pop_front();
            s_tdata  <= DW'({rq.prev_end, rq.comp_start, rq.symbol});
            s_tuser  <= rq.first;
            s_tvalid <= 1'b1;
            send_gap <= next_gap(send_quiet);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (m_tvalid && m_tready) stall_left <= next_gap(stall_quiet);
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                pair_result_t got;
                pair_result_t want;
                got.pair_valid = m_tuser;
                got.open_pos   = m_tdata[15:0];
                got.close_pos  = m_tdata[31:16];
                got.kind       = kind_t'(m_tdata[33:32]);
                got.status     = status_t'(m_tdata[35:34]);
                if (expected_pairs.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: valid=%0b open=%h close=%h kind=%0d status=%0d",
                                 got.pair_valid, got.open_pos, got.close_pos,
                                 got.kind, got.status);
                end else begin
                    want = expected_pairs.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected valid=%0b open=%h close=%h kind=%0d ",
                                      "status=%0d, got valid=%0b open=%h close=%h kind=%0d ",
                                      "status=%0d"},
                                     want.pair_valid, want.open_pos, want.close_pos,
                                     want.kind, want.status, got.pair_valid, got.open_pos,
                                     got.close_pos, got.kind, got.status);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_pairs.insert(expected_pairs.size(),
                                      track_symbol(request_t'({s_tdata[3:0], s_tuser,
                                                               s_tdata[19:4],
                                                               s_tdata[35:20]})));
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int               open_kinds[$];
        int               k;
        int               len;
        int               r;
        logic [POS_W-1:0] cs;

        // directed: wrap, empty closes, all kinds, unused codes, separators
        add_request(SYM_ROUND_OPEN,    1'b1, 16'hFFFF, 16'h0000);
        add_request(SYM_ROUND_CLOSE,   1'b0, 16'h0000, 16'hFFFF);
        add_request(SYM_SQUARE_CLOSE,  1'b0, 16'hFFFF, 16'hFFFF);
        add_request(SYM_CURLY_CLOSE,   1'b0, 16'h0000, 16'h0000);
        add_request(SYM_CHEVRON_CLOSE, 1'b0, 16'hA5A5, 16'h5A5A);
        add_request(SYM_ROUND_CLOSE,   1'b0, 16'h5A5A, 16'hA5A5);
        add_request(SYM_SQUARE_OPEN,   1'b0, 16'h0001, 16'h8000);
        add_request(SYM_CURLY_OPEN,    1'b0, 16'h8000, 16'h0001);
        add_request(SYM_CHEVRON_OPEN,  1'b0, 16'h7FFF, 16'hFFFE);
        add_request(SYM_UNPAIRED,      1'b0, 16'h1234, 16'h4321);
        add_request(4'd15,             1'b0, 16'hFFFF, 16'hFFFF);
        add_request(4'd10,             1'b0, 16'h0000, 16'h0000);
        add_request(SYM_SEPARATOR,     1'b0, 16'h0000, 16'hFFFF);
        add_request(SYM_SEPARATOR,     1'b0, 16'hFFFF, 16'h0000);
        add_request(SYM_CHEVRON_CLOSE, 1'b0, 16'h0000, 16'h0000);
        add_request(SYM_CURLY_CLOSE,   1'b0, 16'h0000, 16'h0000);
        add_request(SYM_SQUARE_CLOSE,  1'b0, 16'h0000, 16'h0000);
        add_request(SYM_SEPARATOR,     1'b1, 16'h1234, 16'hFFFF);
        add_request(SYM_ROUND_OPEN,    1'b0, 16'h0000, 16'h0000);
        add_request(SYM_ROUND_CLOSE,   1'b1, 16'h0000, 16'h0000);
        add_request(SYM_UNPAIRED,      1'b1, 16'hFFFE, 16'h0000);

        // fill every stack past its depth, then unwind part of the way
        add_request(SYM_UNPAIRED, 1'b1, 16'($urandom), 16'($urandom));
        for (int i = 0; i <= STACK_DEPTH; i++)
            for (int j = 0; j < NUM_KINDS; j++)
                add_request(SYM_ROUND_OPEN + 4'(2 * j), 1'b0, 16'($urandom), 16'($urandom));
        for (int i = 0; i < 40; i++)
            add_request(SYM_ROUND_CLOSE + 4'(2 * $urandom_range(0, 3)), 1'b0,
                        16'($urandom), 16'($urandom));

        // random structures, mostly well formed
        while (queued < ITEM_TARGET) begin
            open_kinds.delete();
            r  = $urandom_range(0, 9);
            cs = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(16'hFFC0, 16'hFFFF))
                                             : 16'($urandom);
            if (r == 9) begin
                add_request(SYM_SEPARATOR, 1'b1, cs, 16'($urandom));
            end else if (r == 8) begin
                add_request(4'($urandom_range(0, 15)), 1'b1, cs, 16'($urandom));
            end else begin
                k = $urandom_range(0, 3);
                open_kinds.insert(open_kinds.size(), k);
                add_request(SYM_ROUND_OPEN + 4'(2 * k), 1'b1, cs, 16'($urandom));
            end
            len = $urandom_range(4, 40);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    k = $urandom_range(0, 3);
                    open_kinds.insert(open_kinds.size(), k);
                    add_request(SYM_ROUND_OPEN + 4'(2 * k), 1'b0,
                                16'($urandom), 16'($urandom));
                end else if (r < 70 && open_kinds.size() != 0) begin
                    k = open_kinds.pop_back();
                    add_request(SYM_ROUND_CLOSE + 4'(2 * k), 1'b0,
                                16'($urandom), 16'($urandom));
                end else if (r < 80) begin
                    add_request(SYM_UNPAIRED, 1'b0, 16'($urandom), 16'($urandom));
                end else if (r < 86) begin
                    cs = 16'($urandom);
                    add_request(SYM_SEPARATOR, 1'b0, cs,
                                ($urandom_range(0, 1) == 0) ? 16'(cs - $urandom_range(1, 30))
                                                            : 16'($urandom));
                end else if (r < 91) begin
                    add_request(4'($urandom_range(10, 15)), 1'b0,
                                16'($urandom), 16'($urandom));
                end else begin
                    add_request(SYM_ROUND_CLOSE + 4'(2 * $urandom_range(0, 3)), 1'b0,
                                16'($urandom), 16'($urandom));
                end
            end
            while (open_kinds.size() != 0) begin
                k = open_kinds.pop_back();
                add_request(SYM_ROUND_CLOSE + 4'(2 * k), 1'b0, 16'($urandom), 16'($urandom));
            end
        end

        @(posedge aclk);
        while (!aresetn || requests.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_pairs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (errors == 0 && expected_pairs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
